// ===== src/tti_pkg.sv =====
// Package for the triangle pair intersection pipeline: widths, types and axis codes.
// All widths but VW derive from COORD_WIDTH. No dependencies.
`default_nettype none
package tti_pkg;

	// coordinate width and the fixed width of one packed vertex port
	localparam int COORD_WIDTH = 16;
	localparam int VW = 48;

	// exact widths of the intermediate values
	localparam int DW  = COORD_WIDTH + 1;      // coordinate difference
	localparam int PW  = 2 * DW;               // product of two differences
	localparam int NW  = PW + 1;               // normal component
	localparam int TW  = NW + DW;              // one term of a plane distance
	localparam int DDW = TW + 2;               // plane distance
	localparam int CPW = 2 * NW;               // product of two normal components
	localparam int CW  = CPW + 1;              // line direction component
	localparam int SW  = PW + 2;               // 2-D cross and dot sums
	localparam int MW  = COORD_WIDTH + DDW;    // endpoint product
	localparam int FW  = MW + 2;               // endpoint numerator
	localparam int EW  = DDW + 1;              // endpoint denominator

	// partial products for the cross-multiplied endpoint compare
	localparam int NC   = (FW + 2) / 3;
	localparam int NTOP = FW - 2 * NC;
	localparam int EC   = (EW + 1) / 2;
	localparam int ETOP = EW - EC;
	localparam int PPW  = NC + EC + 2;
	localparam int XW   = FW + EW;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DW-1:0]          diff_t;
	typedef logic signed [PW-1:0]          prod_t;
	typedef logic signed [NW-1:0]          norm_t;
	typedef logic signed [TW-1:0]          term_t;
	typedef logic signed [DDW-1:0]         dist_t;
	typedef logic signed [CPW-1:0]         dcp_t;
	typedef logic signed [CW-1:0]          dcw_t;
	typedef logic signed [SW-1:0]          sum2_t;
	typedef logic signed [MW-1:0]          mprod_t;
	typedef logic signed [FW-1:0]          fnum_t;
	typedef logic signed [EW-1:0]          fden_t;
	typedef logic signed [NC:0]            nck_t;
	typedef logic signed [EC:0]            eck_t;
	typedef logic signed [PPW-1:0]         ppart_t;
	typedef logic signed [XW-1:0]          xw_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

endpackage
`default_nettype wire

// ===== src/triangle_triangle_intersect.sv =====
// Triangle pair intersection test (Moller), exact integer pipeline of eleven stages.
// Depends on tti_pkg for widths, types and axis codes.
//
// Usage: an item is two triangles, tri_a_vertex_0..2 and tri_b_vertex_0..2, each
// vertex packing signed x, y, z coordinates of COORD_WIDTH bits from bit 0 up.
// It is taken at a rising edge with in_valid high and in_stall low. One result,
// hit and coplanar, comes out per item on out_valid/out_stall, in input order.
// Throughput: one item per cycle while the output is not stalled; every stage
// carries a valid bit, so bubbles pass through freely.
// Critical stages: the 35 by 35 bit normal products, the 16 by 54 bit endpoint
// products and the 127 bit sums that rebuild the endpoint cross products from
// 24 by 28 bit partial products.
// Stalls: while out_valid is high and out_stall is high the whole pipeline holds
// and in_stall is raised; nothing is lost or repeated.
// Reset: arst_n clears all valid bits at once; the pipeline is empty afterwards
// and in_stall is low, so it can take an item straight away.
`default_nettype none
module triangle_triangle_intersect (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [tti_pkg::VW-1:0]  tri_a_vertex_0,
	input  wire logic [tti_pkg::VW-1:0]  tri_a_vertex_1,
	input  wire logic [tti_pkg::VW-1:0]  tri_a_vertex_2,
	input  wire logic [tti_pkg::VW-1:0]  tri_b_vertex_0,
	input  wire logic [tti_pkg::VW-1:0]  tri_b_vertex_1,
	input  wire logic [tti_pkg::VW-1:0]  tri_b_vertex_2,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         hit,
	output logic                         coplanar
);
	import tti_pkg::*;

	function automatic logic [NW-1:0] nmag(norm_t v);
		return v[NW-1] ? NW'(-v) : NW'(v);
	endfunction

	function automatic nck_t nchunk(fnum_t n, int c);
		nck_t r;
		logic signed [NTOP-1:0] t;
		r = '0;
		t = n[FW-1:2*NC];
		if (c == 2) r = nck_t'(t);
		else r[NC-1:0] = n[c*NC +: NC];
		return r;
	endfunction

	function automatic eck_t echunk(fden_t e, int d);
		eck_t r;
		r = '0;
		if (d == 1) r[ETOP-1:0] = e[EW-1:EC];
		else r[EC-1:0] = e[EC-1:0];
		return r;
	endfunction

	// pipeline advance
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	assign en       = !(v_s11 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10;
		end
	end

	// stage 1: unpack coordinates, take edges and relative vectors
	logic [VW-1:0] vin [6];
	logic [63:0]   vx  [6];
	coord_t a_in [3][3];
	coord_t b_in [3][3];
	coord_t a_s1 [3][3];
	coord_t b_s1 [3][3];
	diff_t  ea1_s1 [3], ea2_s1 [3], eb1_s1 [3], eb2_s1 [3];
	diff_t  rela_s1 [3][3], relb_s1 [3][3];

	assign vin[0] = tri_a_vertex_0;
	assign vin[1] = tri_a_vertex_1;
	assign vin[2] = tri_a_vertex_2;
	assign vin[3] = tri_b_vertex_0;
	assign vin[4] = tri_b_vertex_1;
	assign vin[5] = tri_b_vertex_2;

	always_comb begin
		for (int i = 0; i < 6; i++) vx[i] = 64'(vin[i]);
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				a_in[i][k] = vx[i][k*COORD_WIDTH +: COORD_WIDTH];
				b_in[i][k] = vx[3+i][k*COORD_WIDTH +: COORD_WIDTH];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_in;
			b_s1 <= b_in;
			for (int k = 0; k < 3; k++) begin
				ea1_s1[k] <= diff_t'(a_in[1][k]) - diff_t'(a_in[0][k]);
				ea2_s1[k] <= diff_t'(a_in[2][k]) - diff_t'(a_in[0][k]);
				eb1_s1[k] <= diff_t'(b_in[1][k]) - diff_t'(b_in[0][k]);
				eb2_s1[k] <= diff_t'(b_in[2][k]) - diff_t'(b_in[0][k]);
				for (int i = 0; i < 3; i++) begin
					rela_s1[i][k] <= diff_t'(a_in[i][k]) - diff_t'(b_in[0][k]);
					relb_s1[i][k] <= diff_t'(b_in[i][k]) - diff_t'(a_in[0][k]);
				end
			end
		end
	end

	// stage 2: products of the normal cross products
	coord_t a_s2 [3][3], b_s2 [3][3];
	diff_t  rela_s2 [3][3], relb_s2 [3][3];
	prod_t  pn1_s2 [3][2], pn2_s2 [3][2];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1; b_s2 <= b_s1;
			rela_s2 <= rela_s1; relb_s2 <= relb_s1;
			for (int k = 0; k < 3; k++) begin
				pn1_s2[k][0] <= prod_t'(ea1_s1[(k+1)%3]) * prod_t'(ea2_s1[(k+2)%3]);
				pn1_s2[k][1] <= prod_t'(ea1_s1[(k+2)%3]) * prod_t'(ea2_s1[(k+1)%3]);
				pn2_s2[k][0] <= prod_t'(eb1_s1[(k+1)%3]) * prod_t'(eb2_s1[(k+2)%3]);
				pn2_s2[k][1] <= prod_t'(eb1_s1[(k+2)%3]) * prod_t'(eb2_s1[(k+1)%3]);
			end
		end
	end

	// stage 3: normals
	coord_t a_s3 [3][3], b_s3 [3][3];
	diff_t  rela_s3 [3][3], relb_s3 [3][3];
	norm_t  n1_s3 [3], n2_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= a_s2; b_s3 <= b_s2;
			rela_s3 <= rela_s2; relb_s3 <= relb_s2;
			for (int k = 0; k < 3; k++) begin
				n1_s3[k] <= norm_t'(pn1_s2[k][0]) - norm_t'(pn1_s2[k][1]);
				n2_s3[k] <= norm_t'(pn2_s2[k][0]) - norm_t'(pn2_s2[k][1]);
			end
		end
	end

	// stage 4: distance terms, line direction products, coplanar projection
	logic          n1zero;
	norm_t         np [3];
	logic [NW-1:0] nm [3];
	axis_t         drop;
	coord_t        pa_c [3][2], pb_c [3][2];
	coord_t        a_s4 [3][3], b_s4 [3][3];
	term_t         ta_s4 [3][3], tb_s4 [3][3];
	dcp_t          dcp_s4 [3][2];
	coord_t        pa_s4 [3][2], pb_s4 [3][2];

	always_comb begin
		n1zero = (n1_s3[0] == '0) && (n1_s3[1] == '0) && (n1_s3[2] == '0);
		for (int k = 0; k < 3; k++) begin
			np[k] = n1zero ? n2_s3[k] : n1_s3[k];
			nm[k] = nmag(np[k]);
		end
		priority if (nm[0] >= nm[1] && nm[0] >= nm[2]) drop = AX_X;
		else if (nm[1] >= nm[2])                     drop = AX_Y;
		else                                         drop = AX_Z;
		for (int i = 0; i < 3; i++) begin
			unique case (drop)
				AX_X: begin
					pa_c[i][0] = a_s3[i][1]; pa_c[i][1] = a_s3[i][2];
					pb_c[i][0] = b_s3[i][1]; pb_c[i][1] = b_s3[i][2];
				end
				AX_Y: begin
					pa_c[i][0] = a_s3[i][0]; pa_c[i][1] = a_s3[i][2];
					pb_c[i][0] = b_s3[i][0]; pb_c[i][1] = b_s3[i][2];
				end
				default: begin
					pa_c[i][0] = a_s3[i][0]; pa_c[i][1] = a_s3[i][1];
					pb_c[i][0] = b_s3[i][0]; pb_c[i][1] = b_s3[i][1];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= a_s3; b_s4 <= b_s3;
			pa_s4 <= pa_c; pb_s4 <= pb_c;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					ta_s4[i][k] <= term_t'(n2_s3[k]) * term_t'(rela_s3[i][k]);
					tb_s4[i][k] <= term_t'(n1_s3[k]) * term_t'(relb_s3[i][k]);
				end
				dcp_s4[i][0] <= dcp_t'(n1_s3[(i+1)%3]) * dcp_t'(n2_s3[(i+2)%3]);
				dcp_s4[i][1] <= dcp_t'(n1_s3[(i+2)%3]) * dcp_t'(n2_s3[(i+1)%3]);
			end
		end
	end

	// stage 5: plane distances, line direction magnitudes, 2-D differences
	dcw_t          dct [3];
	coord_t        a_s5 [3][3], b_s5 [3][3];
	dist_t         da_s5 [3], db_s5 [3];
	logic [CW-1:0] dcm_s5 [3];
	diff_t         ra_s5 [3][2], sb_s5 [3][2], w_s5 [3][3][2];
	diff_t         aa_s5 [2][2], ab_s5 [2][2], va_s5 [3][2], vb_s5 [3][2];

	always_comb begin
		for (int i = 0; i < 3; i++) dct[i] = dcw_t'(dcp_s4[i][0]) - dcw_t'(dcp_s4[i][1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5 <= a_s4; b_s5 <= b_s4;
			for (int i = 0; i < 3; i++) begin
				da_s5[i] <= dist_t'(ta_s4[i][0]) + dist_t'(ta_s4[i][1]) + dist_t'(ta_s4[i][2]);
				db_s5[i] <= dist_t'(tb_s4[i][0]) + dist_t'(tb_s4[i][1]) + dist_t'(tb_s4[i][2]);
				dcm_s5[i] <= dct[i][CW-1] ? CW'(-dct[i]) : CW'(dct[i]);
			end
			for (int c = 0; c < 2; c++) begin
				for (int i = 0; i < 3; i++) begin
					ra_s5[i][c] <= diff_t'(pa_s4[(i+1)%3][c]) - diff_t'(pa_s4[i][c]);
					sb_s5[i][c] <= diff_t'(pb_s4[(i+1)%3][c]) - diff_t'(pb_s4[i][c]);
					va_s5[i][c] <= diff_t'(pb_s4[0][c]) - diff_t'(pa_s4[i][c]);
					vb_s5[i][c] <= diff_t'(pa_s4[0][c]) - diff_t'(pb_s4[i][c]);
					for (int j = 0; j < 3; j++)
						w_s5[i][j][c] <= diff_t'(pb_s4[j][c]) - diff_t'(pa_s4[i][c]);
				end
				aa_s5[0][c] <= diff_t'(pa_s4[1][c]) - diff_t'(pa_s4[0][c]);
				aa_s5[1][c] <= diff_t'(pa_s4[2][c]) - diff_t'(pa_s4[0][c]);
				ab_s5[0][c] <= diff_t'(pb_s4[1][c]) - diff_t'(pb_s4[0][c]);
				ab_s5[1][c] <= diff_t'(pb_s4[2][c]) - diff_t'(pb_s4[0][c]);
			end
		end
	end

	// stage 6: classify the pair, choose line axis and lone vertices, 2-D products
	logic   rej_c, cop_c;
	axis_t  kax;
	coord_t pk [2][3];
	dist_t  dk [2][3];
	logic   sp [2][3], sn [2][3];
	logic [1:0] lone [2];
	coord_t pl_c [2], po1_c [2], po2_c [2];
	dist_t  dl_c [2], do1_c [2], do2_c [2];

	logic   rej_s6, cop_s6;
	coord_t pl_s6 [2], po1_s6 [2], po2_s6 [2];
	dist_t  dl_s6 [2], do1_s6 [2], do2_s6 [2];
	prod_t  pp_s6 [3][3][12];
	prod_t  rrp_s6 [3][2], ssp_s6 [3][2];
	prod_t  arp_s6 [2][2], op_s6 [2][3][2];
	logic   wz_s6 [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sp[0][i] = da_s5[i] > 0; sn[0][i] = da_s5[i] < 0;
			sp[1][i] = db_s5[i] > 0; sn[1][i] = db_s5[i] < 0;
			dk[0][i] = da_s5[i];
			dk[1][i] = db_s5[i];
		end
		rej_c = (sp[0][0] && sp[0][1] && sp[0][2]) || (sn[0][0] && sn[0][1] && sn[0][2]) ||
		        (sp[1][0] && sp[1][1] && sp[1][2]) || (sn[1][0] && sn[1][1] && sn[1][2]);
		cop_c = !rej_c &&
		        ((da_s5[0] == '0 && da_s5[1] == '0 && da_s5[2] == '0) ||
		         (db_s5[0] == '0 && db_s5[1] == '0 && db_s5[2] == '0));
		// largest line direction component, ties to the lower axis
		kax = AX_X;
		if (dcm_s5[1] > dcm_s5[0]) kax = AX_Y;
		if (dcm_s5[2] > ((kax == AX_Y) ? dcm_s5[1] : dcm_s5[0])) kax = AX_Z;
		for (int i = 0; i < 3; i++) begin
			unique case (kax)
				AX_X:    begin pk[0][i] = a_s5[i][0]; pk[1][i] = b_s5[i][0]; end
				AX_Y:    begin pk[0][i] = a_s5[i][1]; pk[1][i] = b_s5[i][1]; end
				default: begin pk[0][i] = a_s5[i][2]; pk[1][i] = b_s5[i][2]; end
			endcase
		end
		for (int t = 0; t < 2; t++) begin
			// vertex on its own side of the other plane
			priority if ((sp[t][0] && sp[t][1]) || (sn[t][0] && sn[t][1])) lone[t] = 2'd2;
			else if ((sp[t][0] && sp[t][2]) || (sn[t][0] && sn[t][2]))   lone[t] = 2'd1;
			else if ((sp[t][1] && sp[t][2]) || (sn[t][1] && sn[t][2]) ||
			         sp[t][0] || sn[t][0])                               lone[t] = 2'd0;
			else if (sp[t][1] || sn[t][1])                               lone[t] = 2'd1;
			else                                                         lone[t] = 2'd2;
			unique case (lone[t])
				2'd0: begin
					pl_c[t] = pk[t][0]; po1_c[t] = pk[t][1]; po2_c[t] = pk[t][2];
					dl_c[t] = dk[t][0]; do1_c[t] = dk[t][1]; do2_c[t] = dk[t][2];
				end
				2'd1: begin
					pl_c[t] = pk[t][1]; po1_c[t] = pk[t][2]; po2_c[t] = pk[t][0];
					dl_c[t] = dk[t][1]; do1_c[t] = dk[t][2]; do2_c[t] = dk[t][0];
				end
				default: begin
					pl_c[t] = pk[t][2]; po1_c[t] = pk[t][0]; po2_c[t] = pk[t][1];
					dl_c[t] = dk[t][2]; do1_c[t] = dk[t][0]; do2_c[t] = dk[t][1];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s6 <= rej_c; cop_s6 <= cop_c;
			pl_s6 <= pl_c; po1_s6 <= po1_c; po2_s6 <= po2_c;
			dl_s6 <= dl_c; do1_s6 <= do1_c; do2_s6 <= do2_c;
			for (int i = 0; i < 3; i++) begin
				rrp_s6[i][0] <= prod_t'(ra_s5[i][0]) * prod_t'(ra_s5[i][0]);
				rrp_s6[i][1] <= prod_t'(ra_s5[i][1]) * prod_t'(ra_s5[i][1]);
				ssp_s6[i][0] <= prod_t'(sb_s5[i][0]) * prod_t'(sb_s5[i][0]);
				ssp_s6[i][1] <= prod_t'(sb_s5[i][1]) * prod_t'(sb_s5[i][1]);
				op_s6[0][i][0] <= prod_t'(ra_s5[i][0]) * prod_t'(va_s5[i][1]);
				op_s6[0][i][1] <= prod_t'(ra_s5[i][1]) * prod_t'(va_s5[i][0]);
				op_s6[1][i][0] <= prod_t'(sb_s5[i][0]) * prod_t'(vb_s5[i][1]);
				op_s6[1][i][1] <= prod_t'(sb_s5[i][1]) * prod_t'(vb_s5[i][0]);
				for (int j = 0; j < 3; j++) begin
					wz_s6[i][j] <= (w_s5[i][j][0] == '0) && (w_s5[i][j][1] == '0);
					pp_s6[i][j][0]  <= prod_t'(ra_s5[i][0]) * prod_t'(sb_s5[j][1]);
					pp_s6[i][j][1]  <= prod_t'(ra_s5[i][1]) * prod_t'(sb_s5[j][0]);
					pp_s6[i][j][2]  <= prod_t'(w_s5[i][j][0]) * prod_t'(sb_s5[j][1]);
					pp_s6[i][j][3]  <= prod_t'(w_s5[i][j][1]) * prod_t'(sb_s5[j][0]);
					pp_s6[i][j][4]  <= prod_t'(w_s5[i][j][0]) * prod_t'(ra_s5[i][1]);
					pp_s6[i][j][5]  <= prod_t'(w_s5[i][j][1]) * prod_t'(ra_s5[i][0]);
					pp_s6[i][j][6]  <= prod_t'(w_s5[i][j][0]) * prod_t'(ra_s5[i][0]);
					pp_s6[i][j][7]  <= prod_t'(w_s5[i][j][1]) * prod_t'(ra_s5[i][1]);
					pp_s6[i][j][8]  <= prod_t'(sb_s5[j][0]) * prod_t'(ra_s5[i][0]);
					pp_s6[i][j][9]  <= prod_t'(sb_s5[j][1]) * prod_t'(ra_s5[i][1]);
					pp_s6[i][j][10] <= prod_t'(w_s5[i][j][0]) * prod_t'(sb_s5[j][0]);
					pp_s6[i][j][11] <= prod_t'(w_s5[i][j][1]) * prod_t'(sb_s5[j][1]);
				end
			end
			arp_s6[0][0] <= prod_t'(aa_s5[0][0]) * prod_t'(aa_s5[1][1]);
			arp_s6[0][1] <= prod_t'(aa_s5[0][1]) * prod_t'(aa_s5[1][0]);
			arp_s6[1][0] <= prod_t'(ab_s5[0][0]) * prod_t'(ab_s5[1][1]);
			arp_s6[1][1] <= prod_t'(ab_s5[0][1]) * prod_t'(ab_s5[1][0]);
		end
	end

	// stage 7: 2-D sums, endpoint products
	logic   rej_s7, cop_s7;
	sum2_t  den_s7 [3][3], tn_s7 [3][3], un_s7 [3][3];
	sum2_t  a0_s7 [3][3], sr_s7 [3][3], ws_s7 [3][3];
	sum2_t  rr_s7 [3], ss_s7 [3], area_s7 [2], o_s7 [2][3];
	logic   wz_s7 [3][3];
	mprod_t m1_s7 [2], m2_s7 [2], m3_s7 [2], m4_s7 [2];
	fden_t  e1_s7 [2], e2_s7 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s7 <= rej_s6; cop_s7 <= cop_s6;
			wz_s7 <= wz_s6;
			for (int i = 0; i < 3; i++) begin
				rr_s7[i] <= sum2_t'(rrp_s6[i][0]) + sum2_t'(rrp_s6[i][1]);
				ss_s7[i] <= sum2_t'(ssp_s6[i][0]) + sum2_t'(ssp_s6[i][1]);
				for (int t = 0; t < 2; t++)
					o_s7[t][i] <= sum2_t'(op_s6[t][i][0]) - sum2_t'(op_s6[t][i][1]);
				for (int j = 0; j < 3; j++) begin
					den_s7[i][j] <= sum2_t'(pp_s6[i][j][0]) - sum2_t'(pp_s6[i][j][1]);
					tn_s7[i][j]  <= sum2_t'(pp_s6[i][j][2]) - sum2_t'(pp_s6[i][j][3]);
					un_s7[i][j]  <= sum2_t'(pp_s6[i][j][4]) - sum2_t'(pp_s6[i][j][5]);
					a0_s7[i][j]  <= sum2_t'(pp_s6[i][j][6]) + sum2_t'(pp_s6[i][j][7]);
					sr_s7[i][j]  <= sum2_t'(pp_s6[i][j][8]) + sum2_t'(pp_s6[i][j][9]);
					ws_s7[i][j]  <= sum2_t'(pp_s6[i][j][10]) + sum2_t'(pp_s6[i][j][11]);
				end
			end
			for (int t = 0; t < 2; t++) begin
				area_s7[t] <= sum2_t'(arp_s6[t][0]) - sum2_t'(arp_s6[t][1]);
				m1_s7[t] <= mprod_t'(po1_s6[t]) * mprod_t'(dl_s6[t]);
				m2_s7[t] <= mprod_t'(pl_s6[t]) * mprod_t'(do1_s6[t]);
				m3_s7[t] <= mprod_t'(po2_s6[t]) * mprod_t'(dl_s6[t]);
				m4_s7[t] <= mprod_t'(pl_s6[t]) * mprod_t'(do2_s6[t]);
				e1_s7[t] <= fden_t'(dl_s6[t]) - fden_t'(do1_s6[t]);
				e2_s7[t] <= fden_t'(dl_s6[t]) - fden_t'(do2_s6[t]);
			end
		end
	end

	// stage 8: segment and containment decisions, endpoint fractions
	logic  seg [3][3];
	logic  pin [2];
	sum2_t a1, lo, hi;
	fnum_t fn1 [2], fn2 [2];

	logic  rej_s8, cop_s8, cph_s8;
	fnum_t fn_s8 [2][2];
	fden_t fe_s8 [2][2];

	always_comb begin
		a1 = '0; lo = '0; hi = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				a1 = a0_s7[i][j] + sr_s7[i][j];
				lo = (a0_s7[i][j] < a1) ? a0_s7[i][j] : a1;
				hi = (a0_s7[i][j] < a1) ? a1 : a0_s7[i][j];
				priority if (den_s7[i][j] > 0)
					seg[i][j] = tn_s7[i][j] >= 0 && tn_s7[i][j] <= den_s7[i][j] &&
					            un_s7[i][j] >= 0 && un_s7[i][j] <= den_s7[i][j];
				else if (den_s7[i][j] < 0)
					seg[i][j] = tn_s7[i][j] <= 0 && tn_s7[i][j] >= den_s7[i][j] &&
					            un_s7[i][j] <= 0 && un_s7[i][j] >= den_s7[i][j];
				else if (un_s7[i][j] != '0)
					seg[i][j] = 1'b0;
				else if (rr_s7[i] > 0)
					seg[i][j] = hi >= 0 && lo <= rr_s7[i];
				else if (ss_s7[j] == '0)
					seg[i][j] = wz_s7[i][j];
				else if (tn_s7[i][j] != '0)
					seg[i][j] = 1'b0;
				else
					seg[i][j] = ws_s7[i][j] <= 0 && (ws_s7[i][j] + ss_s7[j]) >= 0;
			end
		end
		// one vertex of each triangle inside the other
		for (int t = 0; t < 2; t++) begin
			priority if (area_s7[t] > 0)
				pin[t] = o_s7[t][0] >= 0 && o_s7[t][1] >= 0 && o_s7[t][2] >= 0;
			else if (area_s7[t] < 0)
				pin[t] = o_s7[t][0] <= 0 && o_s7[t][1] <= 0 && o_s7[t][2] <= 0;
			else
				pin[t] = 1'b0;
		end
		for (int t = 0; t < 2; t++) begin
			fn1[t] = fnum_t'(m1_s7[t]) - fnum_t'(m2_s7[t]);
			fn2[t] = fnum_t'(m3_s7[t]) - fnum_t'(m4_s7[t]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s8 <= rej_s7; cop_s8 <= cop_s7;
			cph_s8 <= seg[0][0] || seg[0][1] || seg[0][2] ||
			          seg[1][0] || seg[1][1] || seg[1][2] ||
			          seg[2][0] || seg[2][1] || seg[2][2] || pin[0] || pin[1];
			for (int t = 0; t < 2; t++) begin
				fn_s8[t][0] <= e1_s7[t][EW-1] ? -fn1[t] : fn1[t];
				fe_s8[t][0] <= e1_s7[t][EW-1] ? -e1_s7[t] : e1_s7[t];
				fn_s8[t][1] <= e2_s7[t][EW-1] ? -fn2[t] : fn2[t];
				fe_s8[t][1] <= e2_s7[t][EW-1] ? -e2_s7[t] : e2_s7[t];
			end
		end
	end

	// stage 9: partial products of each endpoint cross multiplication
	// pair q = 2*i + j compares endpoint i of A with endpoint j of B
	logic   rej_s9, cop_s9, cph_s9;
	ppart_t px_s9 [4][3][2], py_s9 [4][3][2];

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s9 <= rej_s8; cop_s9 <= cop_s8; cph_s9 <= cph_s8;
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					for (int c = 0; c < 3; c++) begin
						for (int d = 0; d < 2; d++) begin
							px_s9[2*i+j][c][d] <= ppart_t'(nchunk(fn_s8[0][i], c)) *
							                      ppart_t'(echunk(fe_s8[1][j], d));
							py_s9[2*i+j][c][d] <= ppart_t'(nchunk(fn_s8[1][j], c)) *
							                      ppart_t'(echunk(fe_s8[0][i], d));
						end
					end
				end
			end
		end
	end

	// stage 10: rebuild the full cross products
	xw_t  xs [4], ys [4];
	logic rej_s10, cop_s10, cph_s10;
	xw_t  x_s10 [4], y_s10 [4];

	always_comb begin
		for (int q = 0; q < 4; q++) begin
			xs[q] = '0;
			ys[q] = '0;
			for (int c = 0; c < 3; c++) begin
				for (int d = 0; d < 2; d++) begin
					xs[q] = xs[q] + (xw_t'(px_s9[q][c][d]) <<< (c*NC + d*EC));
					ys[q] = ys[q] + (xw_t'(py_s9[q][c][d]) <<< (c*NC + d*EC));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s10 <= rej_s9; cop_s10 <= cop_s9; cph_s10 <= cph_s9;
			x_s10 <= xs;
			y_s10 <= ys;
		end
	end

	// stage 11: interval overlap and the result register
	logic lt_all, gt_all;
	logic hit_s11, cop_s11, rej_s11;

	always_comb begin
		lt_all = 1'b1;
		gt_all = 1'b1;
		for (int q = 0; q < 4; q++) begin
			lt_all = lt_all && (x_s10[q] < y_s10[q]);
			gt_all = gt_all && (y_s10[q] < x_s10[q]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s11 <= rej_s10;
			cop_s11 <= cop_s10;
			priority if (rej_s10) hit_s11 <= 1'b0;
			else if (cop_s10)     hit_s11 <= cph_s10;
			else                  hit_s11 <= !(lt_all || gt_all);
		end
	end

	assign out_valid = v_s11;
	assign hit       = hit_s11;
	assign coplanar  = cop_s11;

	// checks
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted item did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11}))
		else $error("pipeline moved while stalled");

	a_reject_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rej_s11 |-> !hit && !coplanar)
		else $error("rejected pair reported as hit or coplanar");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for triangle_triangle_intersect: directed and random triangle pairs,
// checked against an exact integer intersection predictor. Depends on tti_pkg.
`default_nettype none
module tb_top;
	import tti_pkg::*;

	typedef logic signed [191:0] wide_t;
	typedef logic [5:0][VW-1:0] pair_t;
	typedef struct packed {
		logic hit;
		logic coplanar;
	} verdict_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [VW-1:0] vtx [6] = '{default: '0};
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic coplanar;

	pair_t    pend_q[$];
	verdict_t verdict_q[$];
	int       errors = 0;

	triangle_triangle_intersect dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.tri_a_vertex_0(vtx[0]), .tri_a_vertex_1(vtx[1]), .tri_a_vertex_2(vtx[2]),
		.tri_b_vertex_0(vtx[3]), .tri_b_vertex_1(vtx[4]), .tri_b_vertex_2(vtx[5]),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .coplanar(coplanar)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic longint coord_of(logic [VW-1:0] v, int k);
		coord_t c;
		c = v[k*COORD_WIDTH +: COORD_WIDTH];
		return c;
	endfunction

	function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
		return ax * by - ay * bx;
	endfunction

	function automatic int sgn(longint x);
		return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
	endfunction

	function automatic longint mag(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// closed segment test in 2-D; zero-length edges act as points
	function automatic bit segments_meet(longint p0x, longint p0y, longint p1x, longint p1y,
			longint q0x, longint q0y, longint q1x, longint q1y);
		longint rx, ry, sx, sy, wx, wy, den, tn, un, rr, ss, a0, a1, lo, hi, d;
		rx = p1x - p0x; ry = p1y - p0y;
		sx = q1x - q0x; sy = q1y - q0y;
		wx = q0x - p0x; wy = q0y - p0y;
		den = cross2(rx, ry, sx, sy);
		tn = cross2(wx, wy, sx, sy);
		un = cross2(wx, wy, rx, ry);
		if (den != 0) begin
			if (den < 0) begin
				den = -den; tn = -tn; un = -un;
			end
			return tn >= 0 && tn <= den && un >= 0 && un <= den;
		end
		if (un != 0) return 1'b0;
		rr = rx * rx + ry * ry;
		if (rr > 0) begin
			a0 = wx * rx + wy * ry;
			a1 = a0 + sx * rx + sy * ry;
			lo = (a0 < a1) ? a0 : a1;
			hi = (a0 < a1) ? a1 : a0;
			return hi >= 0 && lo <= rr;
		end
		ss = sx * sx + sy * sy;
		if (ss == 0) return wx == 0 && wy == 0;
		if (tn != 0) return 1'b0;
		d = -(wx * sx + wy * sy);
		return d >= 0 && d <= ss;
	endfunction

	// point inside a projected triangle; flat triangles never contain
	function automatic bit point_inside(longint px, longint py, longint t[3][2]);
		longint area;
		longint o[3];
		area = cross2(t[1][0] - t[0][0], t[1][1] - t[0][1],
			t[2][0] - t[0][0], t[2][1] - t[0][1]);
		if (area == 0) return 1'b0;
		for (int i = 0; i < 3; i++)
			o[i] = cross2(t[(i+1)%3][0] - t[i][0], t[(i+1)%3][1] - t[i][1],
				px - t[i][0], py - t[i][1]);
		if (area > 0) return o[0] >= 0 && o[1] >= 0 && o[2] >= 0;
		return o[0] <= 0 && o[1] <= 0 && o[2] <= 0;
	endfunction

	function automatic bit flat_overlap(longint a[3][3], longint b[3][3], longint n[3]);
		longint pa[3][2];
		longint pb[3][2];
		int i0, i1;
		if (mag(n[0]) >= mag(n[1]) && mag(n[0]) >= mag(n[2])) begin
			i0 = 1; i1 = 2;
		end else if (mag(n[1]) >= mag(n[2])) begin
			i0 = 0; i1 = 2;
		end else begin
			i0 = 0; i1 = 1;
		end
		for (int i = 0; i < 3; i++) begin
			pa[i][0] = a[i][i0]; pa[i][1] = a[i][i1];
			pb[i][0] = b[i][i0]; pb[i][1] = b[i][i1];
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (segments_meet(pa[i][0], pa[i][1], pa[(i+1)%3][0], pa[(i+1)%3][1],
						pb[j][0], pb[j][1], pb[(j+1)%3][0], pb[(j+1)%3][1]))
					return 1'b1;
		return point_inside(pa[0][0], pa[0][1], pb) || point_inside(pb[0][0], pb[0][1], pa);
	endfunction

	// rational position along the line, kept with positive denominator
	function automatic void line_point(longint pl, longint dl, longint po, longint dw,
			output wide_t num, output wide_t den);
		wide_t wpo, wpl, wdl, wdw;
		wpo = po; wpl = pl; wdl = dl; wdw = dw;
		num = wpo * wdl - wpl * wdw;
		den = wdl - wdw;
		if (den < 0) begin
			num = -num; den = -den;
		end
	endfunction

	function automatic bit frac_less(wide_t an, wide_t ae, wide_t bn, wide_t be);
		return an * be < bn * ae;
	endfunction

	function automatic void span_of(longint p[3], longint d[3],
			output wide_t lon, output wide_t loe, output wide_t hin, output wide_t hie);
		int s0, s1, s2, l;
		wide_t n1, e1, n2, e2;
		s0 = sgn(d[0]); s1 = sgn(d[1]); s2 = sgn(d[2]);
		if (s0 * s1 > 0) l = 2;
		else if (s0 * s2 > 0) l = 1;
		else if (s1 * s2 > 0 || s0 != 0) l = 0;
		else if (s1 != 0) l = 1;
		else l = 2;
		line_point(p[l], d[l], p[(l+1)%3], d[(l+1)%3], n1, e1);
		line_point(p[l], d[l], p[(l+2)%3], d[(l+2)%3], n2, e2);
		if (frac_less(n2, e2, n1, e1)) begin
			lon = n2; loe = e2; hin = n1; hie = e1;
		end else begin
			lon = n1; loe = e1; hin = n2; hie = e2;
		end
	endfunction

	function automatic bit strictly_one_side(longint d[3]);
		return (d[0] > 0 && d[1] > 0 && d[2] > 0) || (d[0] < 0 && d[1] < 0 && d[2] < 0);
	endfunction

	function automatic void normal_of(longint t[3][3], output longint n[3]);
		longint e1[3];
		longint e2[3];
		for (int k = 0; k < 3; k++) begin
			e1[k] = t[1][k] - t[0][k];
			e2[k] = t[2][k] - t[0][k];
		end
		n[0] = e1[1] * e2[2] - e1[2] * e2[1];
		n[1] = e1[2] * e2[0] - e1[0] * e2[2];
		n[2] = e1[0] * e2[1] - e1[1] * e2[0];
	endfunction

	function automatic verdict_t intersect_verdict(pair_t item);
		longint a[3][3];
		longint b[3][3];
		longint na[3];
		longint nb[3];
		longint da[3];
		longint db[3];
		longint pa[3];
		longint pb[3];
		wide_t dc[3];
		wide_t alon, aloe, ahin, ahie, blon, bloe, bhin, bhie, x1, x2, y1, y2;
		verdict_t v;
		int k;
		v = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				a[i][j] = coord_of(item[i], j);
				b[i][j] = coord_of(item[3+i], j);
			end
		normal_of(b, nb);
		for (int i = 0; i < 3; i++)
			da[i] = nb[0]*(a[i][0]-b[0][0]) + nb[1]*(a[i][1]-b[0][1]) + nb[2]*(a[i][2]-b[0][2]);
		if (strictly_one_side(da)) return v;
		normal_of(a, na);
		for (int i = 0; i < 3; i++)
			db[i] = na[0]*(b[i][0]-a[0][0]) + na[1]*(b[i][1]-a[0][1]) + na[2]*(b[i][2]-a[0][2]);
		if (strictly_one_side(db)) return v;
		// coplanar pair: project and test in 2-D
		if ((da[0] == 0 && da[1] == 0 && da[2] == 0) || (db[0] == 0 && db[1] == 0 && db[2] == 0)) begin
			v.coplanar = 1'b1;
			if (na[0] == 0 && na[1] == 0 && na[2] == 0) v.hit = flat_overlap(a, b, nb);
			else v.hit = flat_overlap(a, b, na);
			return v;
		end
		// pick the dominant axis of the plane intersection line
		for (int i = 0; i < 3; i++) begin
			x1 = na[(i+1)%3]; y1 = nb[(i+2)%3];
			x2 = na[(i+2)%3]; y2 = nb[(i+1)%3];
			dc[i] = x1 * y1 - x2 * y2;
			if (dc[i] < 0) dc[i] = -dc[i];
		end
		k = 0;
		if (dc[1] > dc[k]) k = 1;
		if (dc[2] > dc[k]) k = 2;
		for (int i = 0; i < 3; i++) begin
			pa[i] = a[i][k]; pb[i] = b[i][k];
		end
		span_of(pa, da, alon, aloe, ahin, ahie);
		span_of(pb, db, blon, bloe, bhin, bhie);
		v.hit = !(frac_less(ahin, ahie, blon, bloe) || frac_less(bhin, bhie, alon, aloe));
		return v;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic [VW-1:0] vertex(int x, int y, int z);
		logic [15:0] xs, ys, zs;
		xs = x; ys = y; zs = z;
		return {zs, ys, xs};
	endfunction

	function automatic int small_coord(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic int edge_coord();
		case ($urandom_range(0, 3))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic add_pair(logic [VW-1:0] a0, logic [VW-1:0] a1, logic [VW-1:0] a2,
			logic [VW-1:0] b0, logic [VW-1:0] b1, logic [VW-1:0] b2);
		pair_t p;
		p[0] = a0; p[1] = a1; p[2] = a2; p[3] = b0; p[4] = b1; p[5] = b2;
		pend_q.push_back(p);
	endtask

	task automatic add_random_pair();
		pair_t p;
		int r, z0, mode;
		mode = $urandom_range(0, 9);
		r = ($urandom_range(0, 3) == 0) ? 2000 : $urandom_range(2, 40);
		z0 = small_coord(r);
		for (int i = 0; i < 6; i++) begin
			case (mode)
				// raw bits
				0: p[i] = {$urandom, $urandom};
				// extreme coordinates
				1: p[i] = vertex(edge_coord(), edge_coord(), edge_coord());
				// both triangles in one plane of constant z
				2, 3: p[i] = vertex(small_coord(r), small_coord(r), z0);
				// A flat in z, B with random z
				4, 5: p[i] = vertex(small_coord(r), small_coord(r),
						(i < 3) ? z0 : small_coord(r));
				// coplanar on a tilted plane x = y
				6: begin
					int t;
					t = small_coord(r);
					p[i] = vertex(t, t, small_coord(r));
				end
				default: p[i] = vertex(small_coord(r), small_coord(r), small_coord(r));
			endcase
		end
		pend_q.push_back(p);
	endtask

	// ---------------- driver ----------------

	int  n_sent = 0;
	bit  draining = 1'b0;
	bit  drained_once = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			bit go;
			if (in_valid && !in_stall) begin
				pair_t cur;
				for (int i = 0; i < 6; i++) cur[i] = vtx[i];
				verdict_q.push_back(intersect_verdict(cur));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				// pause once until every result is back
				if (n_sent == 900 && !drained_once) draining = 1'b1;
				if (draining && verdict_q.size() == 0) begin
					draining = 1'b0;
					drained_once = 1'b1;
				end
				go = !draining && pend_q.size() > 0 &&
					((n_sent >= 1000 && n_sent < 1300) || $urandom_range(0, 99) >= 25);
				if (go) begin
					pair_t nxt;
					nxt = pend_q.pop_front();
					for (int i = 0; i < 6; i++) vtx[i] <= nxt[i];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------

	int n_got = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				verdict_t want;
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result hit=%0b coplanar=%0b", $realtime, hit, coplanar);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (hit !== want.hit) begin
						$display("%0t: hit expected %0b actual %0b", $realtime, want.hit, hit);
						errors++;
					end
					if (coplanar !== want.coplanar) begin
						$display("%0t: coplanar expected %0b actual %0b",
							$realtime, want.coplanar, coplanar);
						errors++;
					end
				end
				n_got++;
				// long hold-off so the pipeline holds and stalls its input
				if (n_got == 200) hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !(n_got >= 1000 && n_got < 1300) && $urandom_range(0, 99) < 25;
			end
		end
	end

	// ---------------- watchdog ----------------

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		// directed pairs
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(0, 0, 5), vertex(10, 0, 5), vertex(0, 10, 5));        // parallel, rejected
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(2, 2, -5), vertex(2, 2, 5), vertex(8, 1, 0));         // crossing
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(20, 20, -5), vertex(20, 20, 5), vertex(30, 21, 0));   // line misses
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(10, 0, 0), vertex(10, 0, 5), vertex(12, 3, -5));      // touching at a vertex
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(2, 2, 0), vertex(4, 2, 0), vertex(2, 4, 0));          // coplanar, contained
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(5, -5, 0), vertex(5, 20, 0), vertex(-3, 3, 0));       // coplanar, edges cross
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(20, 20, 0), vertex(30, 20, 0), vertex(20, 30, 0));    // coplanar, apart
		add_pair(vertex(0, 0, 0), vertex(10, 0, 0), vertex(0, 10, 0),
			vertex(10, 0, 0), vertex(20, 0, 0), vertex(15, -5, 0));      // collinear edges touch
		add_pair(vertex(3, 3, 3), vertex(3, 3, 3), vertex(3, 3, 3),
			vertex(3, 3, 3), vertex(3, 3, 3), vertex(3, 3, 3));          // all points equal
		add_pair(vertex(1, 1, 0), vertex(1, 1, 0), vertex(1, 1, 0),
			vertex(0, 0, 0), vertex(5, 0, 0), vertex(0, 5, 0));          // point in triangle
		add_pair(vertex(0, 0, 0), vertex(4, 4, 4), vertex(8, 8, 8),
			vertex(0, 8, 0), vertex(8, 0, 8), vertex(4, 4, 0));          // A degenerate segment
		add_pair(vertex(0, 0, 0), vertex(0, 4, 0), vertex(0, 0, 4),
			vertex(0, 1, 1), vertex(0, 2, 1), vertex(0, 1, 2));          // coplanar in x
		add_pair(vertex(-32768, -32768, -32768), vertex(32767, -32768, -32768),
			vertex(-32768, 32767, 32767), vertex(32767, 32767, -32768),
			vertex(-32768, 32767, -32768), vertex(32767, -32768, 32767)); // extremes
		add_pair(vertex(32767, 32767, 32767), vertex(-32768, 32767, 32767),
			vertex(32767, -32768, -32768), vertex(-32768, -32768, 32767),
			vertex(32767, -32768, 32767), vertex(-32768, 32767, -32768));
		add_pair('1, '1, '1, '0, '0, '0);
		add_pair({16'h7fff, 16'h8000, 16'h7fff}, {16'h8000, 16'h7fff, 16'h8000}, '0,
			{16'h0000, 16'h7fff, 16'h8000}, {16'h7fff, 16'h0000, 16'h8000}, '1);
		for (int i = 0; i < 1550; i++) add_random_pair();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pend_q.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/tti_pkg.sv
src/triangle_triangle_intersect.sv
sim/tb_top.sv
